// ===== hdl/cpa_pkg.sv =====
package cpa_pkg;

   typedef logic signed [63:0] s64_type;

   localparam s64_type S64_MAX = {1'b0, {63{1'b1}}};
   localparam s64_type S64_MIN = {1'b1, {63{1'b0}}};

   // shared unit operation
   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   // right shift applied to a product
   typedef enum logic [1:0] {
      SH_0,
      SH_16,
      SH_32
   } shift_type;

   // request into the shared arithmetic unit
   typedef struct packed {
      logic         start;
      arith_op_type op;
      shift_type    sh;
      s64_type      a;
      s64_type      b;
   } arith_req_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CFG_KP_OUTER    = 3'd0,
      CFG_KI_OUTER    = 3'd1,
      CFG_KD_OUTER    = 3'd2,
      CFG_OUTER_LIMIT = 3'd3,
      CFG_KP_INNER    = 3'd4,
      CFG_KD_INNER    = 3'd5,
      CFG_PLANT_GAIN  = 3'd6,
      CFG_OBSERVER_BW = 3'd7
   } cfg_idx_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WAIT,
      ST_C_ERR,
      ST_C_ACC,
      ST_C_LIM,
      ST_C_CLAMP,
      ST_C_DER,
      ST_C_P,
      ST_C_I,
      ST_C_D,
      ST_C_OUT,
      ST_I_E1,
      ST_I_P,
      ST_I_D,
      ST_I_U,
      ST_I_CLP,
      ST_I_W2,
      ST_I_B3,
      ST_I_T1,
      ST_I_T1M,
      ST_I_N1,
      ST_I_T2,
      ST_I_T2B,
      ST_I_T2M,
      ST_I_N2,
      ST_I_T3,
      ST_I_N3
   } st_type;

   // saturating add
   function automatic s64_type sadd(input s64_type a, input s64_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   // saturating subtract
   function automatic s64_type ssub(input s64_type a, input s64_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic s64_type clampv(input s64_type v, input s64_type lo, input s64_type hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // magnitude as unsigned
   function automatic logic [63:0] mag_of(input s64_type a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   // signed value from sign and magnitude, saturating
   function automatic s64_type from_mag(input logic neg, input logic ovf, input logic [63:0] lo);
      if (ovf || lo[63]) begin
         return neg ? S64_MIN : S64_MAX;
      end
      return neg ? -s64_type'(lo) : s64_type'(lo);
   endfunction

endpackage

// ===== hdl/cpa_arith.sv =====
module cpa_arith import cpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type req,
   output logic          done,
   output s64_type       res
);

   logic         busy_ff;
   logic         done_ff;
   arith_op_type op_ff;
   shift_type    sh_ff;
   logic         neg_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic [63:0]  rem_ff;
   logic [127:0] prod_ff;
   logic [63:0]  pp_ff;
   logic [6:0]   cnt_ff;
   s64_type      res_ff;

   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [127:0] addend;
   logic [127:0] shifted;
   logic [64:0]  rem_sh;
   logic         ge;
   logic [63:0]  rem_in;
   logic [1:0]   add_sel;

   // partial product operand select
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            a_part = ma_ff[31:0];
            b_part = mb_ff[31:0];
         end
         2'd1: begin
            a_part = ma_ff[31:0];
            b_part = mb_ff[63:32];
         end
         2'd2: begin
            a_part = ma_ff[63:32];
            b_part = mb_ff[31:0];
         end
         default: begin
            a_part = ma_ff[63:32];
            b_part = mb_ff[63:32];
         end
      endcase
   end

   // offset of the partial product being accumulated
   always_comb begin
      add_sel = 2'(cnt_ff - 7'd1);
      case (add_sel)
         2'd0:    addend = {64'd0, pp_ff};
         2'd1:    addend = {32'd0, pp_ff, 32'd0};
         2'd2:    addend = {32'd0, pp_ff, 32'd0};
         default: addend = {pp_ff, 64'd0};
      endcase
   end

   // final shift of the product
   always_comb begin
      case (sh_ff)
         SH_16:   shifted = prod_ff >> 16;
         SH_32:   shifted = prod_ff >> 32;
         default: shifted = prod_ff;
      endcase
   end

   // one restoring division step
   always_comb begin
      rem_sh = {rem_ff, ma_ff[63]};
      ge     = (rem_sh >= {1'b0, mb_ff});
      rem_in = ge ? 64'(rem_sh - {1'b0, mb_ff}) : rem_sh[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            op_ff   <= req.op;
            sh_ff   <= req.sh;
            neg_ff  <= req.a[63] ^ req.b[63];
            ma_ff   <= mag_of(req.a);
            mb_ff   <= mag_of(req.b);
            rem_ff  <= '0;
            prod_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (op_ff == OP_MUL) begin
               if (cnt_ff <= 7'd3) begin
                  pp_ff <= a_part * b_part;
               end
               if (cnt_ff >= 7'd1 && cnt_ff <= 7'd4) begin
                  prod_ff <= prod_ff + addend;
               end
               if (cnt_ff == 7'd5) begin
                  res_ff  <= from_mag(neg_ff, shifted[127:64] != 64'd0, shifted[63:0]);
                  done_ff <= 1'b1;
                  busy_ff <= 1'b0;
               end
            end else begin
               if (!cnt_ff[6]) begin
                  rem_ff <= rem_in;
                  ma_ff  <= {ma_ff[62:0], ge};
               end else begin
                  res_ff  <= from_mag(neg_ff, 1'b0, ma_ff);
                  done_ff <= 1'b1;
                  busy_ff <= 1'b0;
               end
            end
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== hdl/cascade_pid_adrc_controller.sv =====
// channel  | direction | fields (lowest bit first)
// req_     | in        | tuser: req_type; tdata: outer_setpoint, outer_feedback,
//          |           |   inner_setpoint_in, inner_feedback
// rsp_     | out       | tdata: drive, inner_setpoint_used
// csr_     | in        | wr_en, index, wdata (one register write per cycle)
//
// A tick runs the inner loop, after the outer loop on a cascade tick; u needs a
// divide by the plant gain when it is nonzero, and the outer loop one more
// divide when ki_outer is positive. One shared unit does every product and
// quotient. req_tready is high only while the sequencer is idle; a result
// waiting in the output register holds the next tick at its final commit.
// Reset is synchronous, clears the controller state and loads the defaults.
module cascade_pid_adrc_controller import cpa_pkg::*; #(
   parameter int SAMPLE_PERIOD_Q16 = 66,
   parameter int OUTER_PERIOD_Q16  = 66,
   parameter int DRIVE_MIN         = -65536000,
   parameter int DRIVE_MAX         = 65536000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,    // req_type
   input  logic [127:0] req_tdata,    // outer_setpoint, outer_feedback, inner_setpoint_in,
                                      // inner_feedback
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,    // drive, inner_setpoint_used
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam s64_type SAMP64 = s64_type'(SAMPLE_PERIOD_Q16);
   localparam s64_type OPER64 = s64_type'(OUTER_PERIOD_Q16);
   localparam s64_type DMIN64 = s64_type'(DRIVE_MIN);
   localparam s64_type DMAX64 = s64_type'(DRIVE_MAX);

   // configuration
   logic signed [31:0] kp_outer_ff, ki_outer_ff, kd_outer_ff;
   logic [30:0]        outer_limit_ff;
   logic signed [31:0] kp_inner_ff, kd_inner_ff, plant_gain_ff;
   logic [30:0]        observer_bw_ff;

   // controller state
   s64_type            acc_ff;
   logic signed [32:0] last_ff;
   s64_type            z1_ff, z2_ff, z3_ff;

   // tick working registers
   logic signed [31:0] osp_ff, ofb_ff, ifb_ff;
   logic signed [31:0] ref_ff, u_ff;
   logic signed [32:0] err_ff;
   s64_type            lim_ff, t_ff, sum_ff, e_ff, w2_ff, b3_ff, n1_ff, n2_ff;
   logic signed [31:0] drive_ff, used_ff;
   logic               rsp_valid_ff;

   st_type             state_ff, state_in;
   st_type             ret_ff, ret_in;

   arith_req_type      areq;
   logic               a_done;
   s64_type            a_res;

   logic               req_acc;
   logic               out_free;
   logic               ki_pos;
   logic signed [32:0] err_now;
   s64_type            w64, b1, b2, lim_out, dnum, lim_num, lim_small;

   cpa_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (areq),
      .done  (a_done),
      .res   (a_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ki_pos     = (ki_outer_ff > 32'sd0);

   // derived operands
   always_comb begin
      err_now   = {osp_ff[31], osp_ff} - {ofb_ff[31], ofb_ff};
      w64       = s64_type'({33'd0, observer_bw_ff});
      b1        = w64 + (w64 <<< 1);
      b2        = w2_ff + (w2_ff <<< 1);
      lim_out   = s64_type'({33'd0, outer_limit_ff});
      dnum      = (s64_type'(err_ff) - s64_type'(last_ff)) <<< 16;
      lim_num   = {1'b0, outer_limit_ff, 32'd0};
      lim_small = {17'd0, outer_limit_ff, 16'd0};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE:    if (req_acc) state_in = req_tuser ? ST_I_E1 : ST_C_ERR;
         ST_WAIT:    if (a_done) state_in = ret_ff;
         ST_C_ERR:   begin state_in = ST_WAIT; ret_in = ST_C_ACC; end
         ST_C_ACC: begin
            if (ki_pos) begin
               state_in = ST_WAIT;
               ret_in   = ST_C_LIM;
            end else begin
               state_in = ST_C_CLAMP;
            end
         end
         ST_C_LIM:   state_in = ST_C_CLAMP;
         ST_C_CLAMP: begin state_in = ST_WAIT; ret_in = ST_C_DER; end
         ST_C_DER:   begin state_in = ST_WAIT; ret_in = ST_C_P; end
         ST_C_P:     begin state_in = ST_WAIT; ret_in = ST_C_I; end
         ST_C_I:     begin state_in = ST_WAIT; ret_in = ST_C_D; end
         ST_C_D:     state_in = ST_C_OUT;
         ST_C_OUT:   state_in = ST_I_E1;
         ST_I_E1:    begin state_in = ST_WAIT; ret_in = ST_I_P; end
         ST_I_P:     begin state_in = ST_WAIT; ret_in = ST_I_D; end
         ST_I_D:     state_in = ST_I_U;
         ST_I_U:     begin state_in = ST_WAIT; ret_in = ST_I_CLP; end
         ST_I_CLP:   begin state_in = ST_WAIT; ret_in = ST_I_W2; end
         ST_I_W2:    begin state_in = ST_WAIT; ret_in = ST_I_B3; end
         ST_I_B3:    begin state_in = ST_WAIT; ret_in = ST_I_T1; end
         ST_I_T1:    state_in = ST_I_T1M;
         ST_I_T1M:   begin state_in = ST_WAIT; ret_in = ST_I_N1; end
         ST_I_N1:    begin state_in = ST_WAIT; ret_in = ST_I_T2; end
         ST_I_T2:    begin state_in = ST_WAIT; ret_in = ST_I_T2B; end
         ST_I_T2B:   state_in = ST_I_T2M;
         ST_I_T2M:   begin state_in = ST_WAIT; ret_in = ST_I_N2; end
         ST_I_N2:    begin state_in = ST_WAIT; ret_in = ST_I_T3; end
         ST_I_T3:    begin state_in = ST_WAIT; ret_in = ST_I_N3; end
         ST_I_N3:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // requests to the shared unit
   always_comb begin
      areq       = '0;
      areq.op    = OP_MUL;
      areq.sh    = SH_16;
      case (state_ff)
         ST_C_ERR: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(err_now);
            areq.b     = OPER64;
            areq.sh    = SH_0;
         end
         ST_C_ACC: begin
            areq.start = ki_pos;
            areq.op    = OP_DIV;
            areq.a     = lim_num;
            areq.b     = s64_type'(ki_outer_ff);
         end
         ST_C_CLAMP: begin
            areq.start = 1'b1;
            areq.op    = OP_DIV;
            areq.a     = dnum;
            areq.b     = OPER64;
         end
         ST_C_DER: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(kp_outer_ff);
            areq.b     = s64_type'(err_ff);
         end
         ST_C_P: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(ki_outer_ff);
            areq.b     = acc_ff;
            areq.sh    = SH_32;
         end
         ST_C_I: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(kd_outer_ff);
            areq.b     = t_ff;
         end
         ST_I_E1: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(kp_inner_ff);
            areq.b     = ssub(s64_type'(ref_ff) <<< 16, z1_ff);
         end
         ST_I_P: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(kd_inner_ff);
            areq.b     = ssub('0, z2_ff);
         end
         ST_I_U: begin
            areq.start = 1'b1;
            if (plant_gain_ff != 32'sd0) begin
               areq.op = OP_DIV;
               areq.a  = ssub(sum_ff, z3_ff);
               areq.b  = s64_type'(plant_gain_ff);
            end else begin
               areq.a  = sum_ff;
               areq.b  = 64'sd1;
            end
         end
         ST_I_CLP: begin
            areq.start = 1'b1;
            areq.a     = w64;
            areq.b     = w64;
         end
         ST_I_W2: begin
            areq.start = 1'b1;
            areq.a     = a_res;
            areq.b     = w64;
         end
         ST_I_B3: begin
            areq.start = 1'b1;
            areq.a     = b1;
            areq.b     = e_ff;
         end
         ST_I_T1M, ST_I_T2M: begin
            areq.start = 1'b1;
            areq.a     = SAMP64;
            areq.b     = t_ff;
         end
         ST_I_N1: begin
            areq.start = 1'b1;
            areq.a     = b2;
            areq.b     = e_ff;
         end
         ST_I_T2: begin
            areq.start = 1'b1;
            areq.a     = s64_type'(plant_gain_ff);
            areq.b     = s64_type'(u_ff);
            areq.sh    = SH_0;
         end
         ST_I_N2: begin
            areq.start = 1'b1;
            areq.a     = b3_ff;
            areq.b     = e_ff;
         end
         ST_I_T3: begin
            areq.start = 1'b1;
            areq.a     = SAMP64;
            areq.b     = a_res;
         end
         default: areq.start = 1'b0;
      endcase
   end

   // sequencer and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (state_ff == ST_I_N3 && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_outer_ff    <= 32'sd65536;
         ki_outer_ff    <= 32'sd6554;
         kd_outer_ff    <= 32'sd0;
         outer_limit_ff <= 31'd65536000;
         kp_inner_ff    <= 32'sd655360;
         kd_inner_ff    <= 32'sd65536;
         plant_gain_ff  <= 32'sd65536;
         observer_bw_ff <= 31'd6553600;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_KP_OUTER:    kp_outer_ff    <= csr_wdata;
            CFG_KI_OUTER:    ki_outer_ff    <= csr_wdata;
            CFG_KD_OUTER:    kd_outer_ff    <= csr_wdata;
            CFG_OUTER_LIMIT: outer_limit_ff <= csr_wdata[30:0];
            CFG_KP_INNER:    kp_inner_ff    <= csr_wdata;
            CFG_KD_INNER:    kd_inner_ff    <= csr_wdata;
            CFG_PLANT_GAIN:  plant_gain_ff  <= csr_wdata;
            CFG_OBSERVER_BW: observer_bw_ff <= csr_wdata[30:0];
            default:         kp_outer_ff    <= kp_outer_ff;
         endcase
      end
   end

   // controller state, committed at its step of the tick
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         last_ff <= '0;
         z1_ff   <= '0;
         z2_ff   <= '0;
         z3_ff   <= '0;
      end else begin
         case (state_ff)
            ST_C_ACC:   acc_ff <= sadd(acc_ff, a_res);
            ST_C_CLAMP: acc_ff <= clampv(acc_ff, -lim_ff, lim_ff);
            ST_C_OUT:   last_ff <= err_ff;
            ST_I_N3: begin
               if (out_free) begin
                  z1_ff <= n1_ff;
                  z2_ff <= n2_ff;
                  z3_ff <= sadd(z3_ff, a_res);
               end
            end
            default:    acc_ff <= acc_ff;
         endcase
      end
   end

   // tick working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               osp_ff <= req_tdata[31:0];
               ofb_ff <= req_tdata[63:32];
               ifb_ff <= req_tdata[127:96];
               ref_ff <= req_tdata[95:64];
            end
         end
         ST_C_ERR:   err_ff <= err_now;
         ST_C_ACC:   if (!ki_pos) lim_ff <= lim_small;
         ST_C_LIM:   lim_ff <= a_res;
         ST_C_DER:   t_ff <= a_res;
         ST_C_P:     sum_ff <= a_res;
         ST_C_I:     sum_ff <= sadd(sum_ff, a_res);
         ST_C_D:     sum_ff <= sadd(sum_ff, a_res);
         ST_C_OUT:   ref_ff <= 32'(clampv(sum_ff, -lim_out, lim_out));
         ST_I_P:     sum_ff <= a_res;
         ST_I_D:     sum_ff <= sadd(sum_ff, a_res);
         ST_I_CLP: begin
            u_ff <= 32'(clampv(a_res, DMIN64, DMAX64));
            e_ff <= ssub(s64_type'(ifb_ff) <<< 16, z1_ff);
         end
         ST_I_W2:    w2_ff <= a_res;
         ST_I_B3:    b3_ff <= a_res;
         ST_I_T1:    t_ff <= sadd(z2_ff, a_res);
         ST_I_N1:    n1_ff <= sadd(z1_ff, a_res);
         ST_I_T2:    t_ff <= sadd(z3_ff, a_res);
         ST_I_T2B:   t_ff <= sadd(t_ff, a_res);
         ST_I_N2:    n2_ff <= sadd(z2_ff, a_res);
         ST_I_N3: begin
            if (out_free) begin
               drive_ff <= u_ff;
               used_ff  <= ref_ff;
            end
         end
         default:    t_ff <= t_ff;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {used_ff, drive_ff};

endmodule

// ===== sim/tb_top.sv =====
module tb_top import cpa_pkg::*; ();

   localparam int LAT_CYCLES = 500;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1350;

   // one control tick worth of input
   typedef struct {
      logic              tick_type;
      logic signed [31:0] outer_sp;
      logic signed [31:0] outer_meas;
      logic signed [31:0] inner_sp;
      logic signed [31:0] inner_meas;
   } tick_item_type;

   // tick predictor and expected drive store
   class tick_scoreboard;
      s64_type kp_o, ki_o, kd_o, lim_o, kp_i, kd_i, b0, bw;
      s64_type integ, err_last, z1, z2, z3;
      logic [31:0] drive_q[$];
      logic [31:0] setpoint_q[$];
      int errors;
      int ticks;
      int cascade_ticks;

      function new();
         kp_o = 65536; ki_o = 6554; kd_o = 0; lim_o = 65536000;
         kp_i = 655360; kd_i = 65536; b0 = 65536; bw = 6553600;
         integ = 0; err_last = 0; z1 = 0; z2 = 0; z3 = 0;
         errors = 0; ticks = 0; cascade_ticks = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      function s64_type sat_add(s64_type a, s64_type b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
         return s[63:0];
      endfunction

      function s64_type sat_sub(s64_type a, s64_type b);
         logic signed [64:0] s;
         s = {a[63], a} - {b[63], b};
         if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
         return s[63:0];
      endfunction

      // exact product, magnitude shifted toward zero, then saturated
      function s64_type mul_shift(s64_type a, s64_type b, int sh);
         logic signed [127:0] p;
         logic [127:0] m;
         logic neg;
         p = 128'(a) * 128'(b);
         neg = (a < 0) != (b < 0);
         m = p[127] ? -p : p;
         m = m >> sh;
         if (m[127:63] != 0) return neg ? S64_MIN : S64_MAX;
         return neg ? -s64_type'(m[63:0]) : s64_type'(m[63:0]);
      endfunction

      function s64_type trunc_div(s64_type num, s64_type den);
         logic [63:0] q;
         logic neg;
         neg = (num < 0) != (den < 0);
         q = (num[63] ? 64'(-num) : 64'(num)) / (den[63] ? 64'(-den) : 64'(den));
         if (q[63]) return neg ? S64_MIN : S64_MAX;
         return neg ? -s64_type'(q) : s64_type'(q);
      endfunction

      function s64_type clip(s64_type v, s64_type lo, s64_type hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(cfg_idx_type idx, logic [31:0] val);
         case (idx)
            CFG_KP_OUTER:    kp_o = s64_type'(signed'(val));
            CFG_KI_OUTER:    ki_o = s64_type'(signed'(val));
            CFG_KD_OUTER:    kd_o = s64_type'(signed'(val));
            CFG_OUTER_LIMIT: lim_o = s64_type'({33'd0, val[30:0]});
            CFG_KP_INNER:    kp_i = s64_type'(signed'(val));
            CFG_KD_INNER:    kd_i = s64_type'(signed'(val));
            CFG_PLANT_GAIN:  b0 = s64_type'(signed'(val));
            CFG_OBSERVER_BW: bw = s64_type'({33'd0, val[30:0]});
            default: ;
         endcase
      endfunction

      function s64_type outer_step(s64_type r, s64_type f);
         s64_type err, lim, der, acc;
         err = r - f;
         integ = sat_add(integ, mul_shift(err, 66, 0));
         if (ki_o > 0) lim = trunc_div(lim_o <<< 32, ki_o);
         else lim = lim_o * 65536;
         integ = clip(integ, -lim, lim);
         der = trunc_div((err - err_last) * 65536, 66);
         acc = mul_shift(kp_o, err, 16);
         acc = sat_add(acc, mul_shift(ki_o, integ, 32));
         acc = sat_add(acc, mul_shift(kd_o, der, 16));
         err_last = err;
         return clip(acc, -lim_o, lim_o);
      endfunction

      function s64_type inner_step(s64_type r, s64_type f);
         s64_type e1, e2, u0, u, e, g1, g2, g3, w2, t, n1, n2, n3;
         e1 = sat_sub(r * 65536, z1);
         e2 = sat_sub(0, z2);
         u0 = sat_add(mul_shift(kp_i, e1, 16), mul_shift(kd_i, e2, 16));
         if (b0 != 0) u = trunc_div(sat_sub(u0, z3), b0);
         else u = mul_shift(u0, 1, 16);
         u = clip(u, -65536000, 65536000);
         g1 = 3 * bw;
         w2 = mul_shift(bw, bw, 16);
         g2 = 3 * w2;
         g3 = mul_shift(w2, bw, 16);
         e = sat_sub(f * 65536, z1);
         t = sat_add(z2, mul_shift(g1, e, 16));
         n1 = sat_add(z1, mul_shift(66, t, 16));
         t = sat_add(sat_add(z3, mul_shift(g2, e, 16)), mul_shift(b0, u, 0));
         n2 = sat_add(z2, mul_shift(66, t, 16));
         t = mul_shift(g3, e, 16);
         n3 = sat_add(z3, mul_shift(66, t, 16));
         z1 = n1; z2 = n2; z3 = n3;
         return u;
      endfunction

      // accepted input transaction: predict its result
      function void note_tick(tick_item_type it);
         s64_type r, u;
         ticks++;
         if (it.tick_type == 1'b0) begin
            cascade_ticks++;
            r = outer_step(s64_type'(it.outer_sp), s64_type'(it.outer_meas));
         end else begin
            r = s64_type'(it.inner_sp);
         end
         u = inner_step(r, s64_type'(it.inner_meas));
         drive_q.push_back(u[31:0]);
         setpoint_q.push_back(r[31:0]);
      endfunction

      // accepted result transaction: compare with oldest prediction
      task check_result(logic [63:0] data);
         logic [31:0] d, s;
         if (drive_q.size() == 0) begin
            report($sformatf("unexpected result %h", data));
         end else begin
            d = drive_q.pop_front();
            s = setpoint_q.pop_front();
            if (data[31:0] !== d)
               report($sformatf("drive got %h want %h", data[31:0], d));
            if (data[63:32] !== s)
               report($sformatf("inner setpoint got %h want %h", data[63:32], s));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   tick_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;

   cascade_pid_adrc_controller dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: check and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** cascade_pid_adrc_controller: FAILED **");
         $finish;
      end
   end

   // one register write, enable dropped for a cycle afterwards
   task write_csr(cfg_idx_type idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // one input transaction, valid held until accepted
   task send_tick(tick_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.tick_type;
      req_tdata <= {it.inner_meas, it.inner_sp, it.outer_meas, it.outer_sp};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(it);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.drive_q.size() != 0) @(posedge clock);
      repeat (LAT_CYCLES) @(posedge clock);
   endtask

   function logic [31:0] edge_val(int k);
      case (k % 6)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // mostly moderate Q16.16 values, sometimes anything
   function logic [31:0] rand_q16();
      if ($urandom_range(9) == 0) return $urandom;
      return 32'(signed'($urandom_range(0, 4000 << 16)) - (2000 <<< 16));
   endfunction

   function logic [31:0] rand_gain();
      case ($urandom_range(7))
         0: return $urandom;
         1: return 32'h0;
         2: return edge_val($urandom_range(5));
         default: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 <<< 16));
      endcase
   endfunction

   task program_random();
      write_csr(CFG_KP_OUTER, rand_gain());
      write_csr(CFG_KI_OUTER, rand_gain());
      write_csr(CFG_KD_OUTER, rand_gain());
      write_csr(CFG_OUTER_LIMIT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 2000 << 16));
      write_csr(CFG_KP_INNER, rand_gain());
      write_csr(CFG_KD_INNER, rand_gain());
      write_csr(CFG_PLANT_GAIN, rand_gain());
      write_csr(CFG_OBSERVER_BW, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 200 << 16));
   endtask

   tick_item_type item;
   int sent;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks on register defaults: field extremes, both tick kinds
      for (int k = 0; k < 20; k++) begin
         item.tick_type = k[0];
         item.outer_sp = edge_val(k);
         item.outer_meas = edge_val(k + 1 + k / 6);
         item.inner_sp = edge_val(k + 2);
         item.inner_meas = edge_val(k + 3 + k / 6);
         send_tick(item);
      end
      drain();

      // extreme register settings, zero plant gain
      write_csr(CFG_KP_OUTER, 32'h7fff_ffff);
      write_csr(CFG_KI_OUTER, 32'h7fff_ffff);
      write_csr(CFG_KD_OUTER, 32'h8000_0000);
      write_csr(CFG_OUTER_LIMIT, 32'h7fff_ffff);
      write_csr(CFG_KP_INNER, 32'h8000_0000);
      write_csr(CFG_KD_INNER, 32'h7fff_ffff);
      write_csr(CFG_PLANT_GAIN, 32'h0);
      write_csr(CFG_OBSERVER_BW, 32'h7fff_ffff);
      for (int k = 0; k < 4; k++) begin
         item.tick_type = k[0];
         item.outer_sp = edge_val(k);
         item.outer_meas = edge_val(k + 1);
         item.inner_sp = edge_val(k + 3);
         item.inner_meas = edge_val(k + 2);
         send_tick(item);
      end
      drain();

      // zero limit, negative integral gain, zero bandwidth, most negative plant gain
      write_csr(CFG_KI_OUTER, 32'hffff_0000);
      write_csr(CFG_OUTER_LIMIT, 32'h0);
      write_csr(CFG_OBSERVER_BW, 32'h0);
      write_csr(CFG_PLANT_GAIN, 32'h8000_0000);
      for (int k = 0; k < 2; k++) begin
         item.tick_type = k[0];
         item.outer_sp = edge_val(k + 1);
         item.outer_meas = edge_val(k);
         item.inner_sp = edge_val(k);
         item.inner_meas = edge_val(k + 1);
         send_tick(item);
      end
      drain();

      // random phases with fresh settings each time
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 30; recv_idle_pct = 78;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 78; recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         program_random();
         for (int k = 0; k < 150; k++) begin
            item.tick_type = ($urandom_range(2) == 0);
            item.outer_sp = rand_q16();
            item.outer_meas = rand_q16();
            item.inner_sp = rand_q16();
            item.inner_meas = rand_q16();
            send_tick(item);
            sent++;
         end
         drain();
      end

      $display("ran %0d ticks (%0d cascade) over default, extreme and random settings",
               sb.ticks, sb.cascade_ticks);
      $display("sender and receiver stalls swapped, then run back to back; %0d mismatches",
               sb.errors);
      if (sb.errors == 0 && sb.drive_q.size() == 0) begin
         $display("** cascade_pid_adrc_controller: PASSED **");
      end else begin
         $display("** cascade_pid_adrc_controller: FAILED **");
      end
      $finish;
   end
endmodule
